### rtl/esd_pkg.sv
package esd_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_ESC = 8'h1B;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_DEL = 8'h7F;
  localparam logic [7:0] CODE_RS = 8'h1E;
  localparam logic [7:0] CODE_US = 8'h1F;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_OCT,
    MODE_CTL
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_string;
  } out_item_t;

  typedef struct packed {
    mode_e      mode;
    logic [8:0] accum;
    logic [1:0] count;
  } state_t;

  localparam state_t STATE_RESET = '{mode: MODE_TEXT, accum: 9'd0, count: 2'd0};

  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;
    logic [2:0]                 n;
  } bnd_t;

  function automatic bnd_t bnd_push(bnd_t b, logic [7:0] v);
    bnd_t r;
    r = b;
    if (r.n != 3'(MaxResults)) begin
      r.data[r.n[1:0]] = v;
      r.n = r.n + 3'd1;
    end
    return r;
  endfunction

  function automatic bnd_t oct_flush(bnd_t b, logic [8:0] v, logic [1:0] n);
    bnd_t       r;
    logic [8:0] sh;
    r = b;
    if (v != 9'd0 && v[8] == 1'b0) begin
      r = bnd_push(r, v[7:0]);
    end else begin
      r = bnd_push(r, CH_BSLASH);
      for (int i = 3; i >= 1; i--) begin
        if (i <= int'(n)) begin
          sh = v >> (3 * (i - 1));
          r = bnd_push(r, {CH_ZERO[7:3], sh[2:0]});
        end
      end
    end
    return r;
  endfunction

endpackage

### rtl/esd_decode.sv
module esd_decode import esd_pkg::*; (
  input  in_item_t item_i,
  input  state_t   state_i,
  output state_t   state_o,
  output bnd_t     bnd_o
);

  logic [7:0] c;
  logic       oct_digit;
  logic       ctl_ok;
  bnd_t       b;
  state_t     s;

  always_comb begin
    c = item_i.in_byte;
    oct_digit = (c >= CH_ZERO) && (c <= CH_SEVEN);
    ctl_ok = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c > CH_UPPER_Z) && (c < CH_BACKTICK));
    b = '0;
    s = state_i;

    unique case (state_i.mode)
      MODE_TEXT: begin
        if (c == CH_BSLASH) begin
          s.mode = MODE_ESC;
        end else begin
          b = bnd_push(b, c);
        end
      end
      MODE_ESC: begin
        s.mode = MODE_TEXT;
        if (oct_digit) begin
          s.mode = MODE_OCT;
          s.accum = {6'd0, c[2:0]};
          s.count = 2'd1;
        end else begin
          unique case (c)
            CH_UPPER_C: s.mode = MODE_CTL;
            CH_LOWER_B: b = bnd_push(b, CODE_BS);
            CH_UPPER_E: b = bnd_push(b, CODE_ESC);
            CH_LOWER_F: b = bnd_push(b, CODE_FF);
            CH_LOWER_N: b = bnd_push(b, CODE_LF);
            CH_LOWER_R: b = bnd_push(b, CODE_CR);
            CH_LOWER_T: b = bnd_push(b, CODE_TAB);
            CH_BSLASH:  b = bnd_push(b, CH_BSLASH);
            default: begin
              b = bnd_push(b, CH_BSLASH);
              b = bnd_push(b, c);
            end
          endcase
        end
      end
      MODE_OCT: begin
        if (oct_digit && state_i.count != 2'd3) begin
          s.accum = {state_i.accum[5:0], c[2:0]};
          s.count = state_i.count + 2'd1;
          if (s.count == 2'd3) begin
            b = oct_flush(b, s.accum, s.count);
            s = STATE_RESET;
          end
        end else begin
          b = oct_flush(b, state_i.accum, state_i.count);
          s = STATE_RESET;
          if (c == CH_BSLASH) begin
            s.mode = MODE_ESC;
          end else begin
            b = bnd_push(b, c);
          end
        end
      end
      MODE_CTL: begin
        s.mode = MODE_TEXT;
        priority if (c == CH_QUESTION) begin
          b = bnd_push(b, CODE_DEL);
        end else if (c == CH_TILDE) begin
          b = bnd_push(b, CODE_RS);
        end else if (c == CH_SLASH) begin
          b = bnd_push(b, CODE_US);
        end else if (ctl_ok) begin
          b = bnd_push(b, {3'd0, c[4:0]});
        end else begin
          b = bnd_push(b, CH_BSLASH);
          b = bnd_push(b, CH_UPPER_C);
          b = bnd_push(b, c);
        end
      end
      default: s = STATE_RESET;
    endcase

    if (item_i.is_last) begin
      unique case (s.mode)
        MODE_TEXT: b = b;
        MODE_ESC:  b = bnd_push(b, CH_BSLASH);
        MODE_OCT:  b = oct_flush(b, s.accum, s.count);
        MODE_CTL: begin
          b = bnd_push(b, CH_BSLASH);
          b = bnd_push(b, CH_UPPER_C);
        end
        default: b = b;
      endcase
      s = STATE_RESET;
    end

    state_o = s;
    bnd_o = b;
  end

endmodule

### rtl/escape_sequence_decoder.sv
// Decodes backslash escapes in a byte stream, one input byte per transfer, with is_last
// marking the final byte of a string. An accepted byte is held in the input register
// and is decoded into a group of zero to four result bytes, which the result
// register hands out one transfer per cycle while out_stall_i is low. A byte leaves
// the input register only when the result register is empty or hands out the final
// result of its group; until then in_stall_o holds off the next byte. last_of_run flags
// the final result of each input byte and end_of_string the final result of a string.
module escape_sequence_decoder import esd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       s1_valid_q;
  in_item_t   s1_q;
  state_t     state_q;
  state_t     state_d;
  bnd_t       dec;
  logic       bnd_valid_q;
  bnd_t       bnd_q;
  logic       bnd_eos_q;
  logic [1:0] idx_q;
  logic       bnd_final;
  logic       out_xfer;
  logic       bnd_free;
  logic       s1_move;
  logic       in_xfer;

  esd_decode u_decode (
    .item_i  (s1_q),
    .state_i (state_q),
    .state_o (state_d),
    .bnd_o   (dec)
  );

  assign bnd_final = ({1'b0, idx_q} == (bnd_q.n - 3'd1));
  assign out_xfer = bnd_valid_q && !out_stall_i;
  assign bnd_free = !bnd_valid_q || (out_xfer && bnd_final);
  assign s1_move = s1_valid_q && bnd_free;
  assign in_stall_o = s1_valid_q && !bnd_free;
  assign in_xfer = in_valid_i && !in_stall_o;

  assign out_valid_o = bnd_valid_q;
  assign out_item_o.out_byte = bnd_q.data[idx_q];
  assign out_item_o.last_of_run = bnd_final;
  assign out_item_o.end_of_string = bnd_final && bnd_eos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q <= STATE_RESET;
      bnd_valid_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        state_q <= state_d;
        bnd_valid_q <= (dec.n != 3'd0);
        idx_q <= 2'd0;
      end else if (out_xfer) begin
        if (bnd_final) begin
          bnd_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_item_i;
    end
    if (s1_move) begin
      bnd_q <= dec;
      bnd_eos_q <= s1_q.is_last;
    end
  end

`ifndef SYNTHESIS
  a_bnd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_valid_q |-> (bnd_q.n != 3'd0 && {1'b0, idx_q} < bnd_q.n))
    else $error("result group empty or index beyond its count");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_q.is_last) |=> (state_q.mode == MODE_TEXT && state_q.count == 2'd0))
    else $error("decoder state not cleared after the end of a string");

  a_oct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_OCT) |-> (state_q.count == 2'd1 || state_q.count == 2'd2))
    else $error("octal digit count out of range");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bnd_valid_q && out_stall_i) |=> (bnd_valid_q && $stable(idx_q)))
    else $error("stalled result group advanced");
`endif

endmodule

### tb/escape_sequence_decoder_test.sv
module escape_sequence_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esd_pkg::*;

  localparam logic [7:0] CTRL_MASK = 8'h1F;
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  class decode_scoreboard;
    mode_e      mode;
    logic [8:0] octal_value;
    logic [1:0] octal_digits;
    logic [7:0] step_bytes[$];
    out_item_t  awaited[$];
    int         errors;

    function new();
      mode = MODE_TEXT;
      octal_value = '0;
      octal_digits = '0;
      errors = 0;
    endfunction

    function void put_byte(logic [7:0] b);
      if (step_bytes.size() < MaxResults) step_bytes.push_back(b);
    endfunction

    function void flush_octal();
      if (octal_value != 9'd0 && octal_value < 9'd256) begin
        put_byte(octal_value[7:0]);
      end else begin
        put_byte(CH_BSLASH);
        for (int i = octal_digits; i > 0; i--) begin
          put_byte(CH_ZERO | 8'((octal_value >> (3 * (i - 1))) & 9'd7));
        end
      end
      mode = MODE_TEXT;
      octal_value = '0;
      octal_digits = '0;
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == CH_BSLASH) mode = MODE_ESC;
      else put_byte(c);
    endfunction

    function void escaped_char(logic [7:0] c);
      mode = MODE_TEXT;
      if (c >= CH_ZERO && c <= CH_SEVEN) begin
        mode = MODE_OCT;
        octal_value = {6'd0, c[2:0]};
        octal_digits = 2'd1;
      end else begin
        case (c)
          CH_UPPER_C: mode = MODE_CTL;
          CH_LOWER_B: put_byte(CODE_BS);
          CH_UPPER_E: put_byte(CODE_ESC);
          CH_LOWER_F: put_byte(CODE_FF);
          CH_LOWER_N: put_byte(CODE_LF);
          CH_LOWER_R: put_byte(CODE_CR);
          CH_LOWER_T: put_byte(CODE_TAB);
          CH_BSLASH:  put_byte(CH_BSLASH);
          default: begin
            put_byte(CH_BSLASH);
            put_byte(c);
          end
        endcase
      end
    endfunction

    function void control_char(logic [7:0] c);
      mode = MODE_TEXT;
      if (c == CH_QUESTION) put_byte(CODE_DEL);
      else if (c == CH_TILDE) put_byte(CODE_RS);
      else if (c == CH_SLASH) put_byte(CODE_US);
      else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c > CH_UPPER_Z && c < CH_BACKTICK)) begin
        put_byte(c & CTRL_MASK);
      end else begin
        put_byte(CH_BSLASH);
        put_byte(CH_UPPER_C);
        put_byte(c);
      end
    endfunction

    function void take_char(in_item_t item);
      out_item_t r;
      step_bytes.delete();
      case (mode)
        MODE_TEXT: plain_char(item.in_byte);
        MODE_ESC:  escaped_char(item.in_byte);
        MODE_OCT: begin
          if (item.in_byte >= CH_ZERO && item.in_byte <= CH_SEVEN && octal_digits < 2'd3) begin
            octal_value = {octal_value[5:0], item.in_byte[2:0]};
            octal_digits = octal_digits + 2'd1;
            if (octal_digits == 2'd3) flush_octal();
          end else begin
            flush_octal();
            plain_char(item.in_byte);
          end
        end
        default:   control_char(item.in_byte);
      endcase
      if (item.is_last) begin
        case (mode)
          MODE_ESC: put_byte(CH_BSLASH);
          MODE_OCT: flush_octal();
          MODE_CTL: begin
            put_byte(CH_BSLASH);
            put_byte(CH_UPPER_C);
          end
          default: ;
        endcase
        mode = MODE_TEXT;
        octal_value = '0;
        octal_digits = '0;
      end
      foreach (step_bytes[i]) begin
        r.out_byte = step_bytes[i];
        r.last_of_run = (i == step_bytes.size() - 1);
        r.end_of_string = r.last_of_run & item.is_last;
        awaited.push_back(r);
      end
    endfunction

    function void check_decoded(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        $error("unexpected output transfer: out_byte %02h", got.out_byte);
        errors++;
      end else begin
        exp = awaited.pop_front();
        if (got.out_byte !== exp.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
          errors++;
        end
        if (got.last_of_run !== exp.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", exp.last_of_run, got.last_of_run);
          errors++;
        end
        if (got.end_of_string !== exp.end_of_string) begin
          $error("end_of_string: expected %0b, got %0b", exp.end_of_string, got.end_of_string);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned stuck_cycles = 0;

  decode_scoreboard sb;

  escape_sequence_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both transfers of a cycle are judged here, on the values held before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_char(in_item);
      if (out_valid && !out_stall) sb.check_decoded(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("escape_sequence_decoder_test NOT OK");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_byte: b, is_last: last};
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(string s, logic ends);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && i == s.len() - 1);
  endtask

  task automatic add_token(ref logic [7:0] text[$]);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      text.push_back(8'($urandom_range(255)));
    end else if (pick < 40) begin
      text.push_back(CH_BSLASH);
      case ($urandom_range(6))
        0: text.push_back(CH_LOWER_B);
        1: text.push_back(CH_UPPER_E);
        2: text.push_back(CH_LOWER_F);
        3: text.push_back(CH_LOWER_N);
        4: text.push_back(CH_LOWER_R);
        5: text.push_back(CH_LOWER_T);
        default: text.push_back(CH_BSLASH);
      endcase
    end else if (pick < 60) begin
      text.push_back(CH_BSLASH);
      repeat ($urandom_range(1, 3)) text.push_back(8'(CH_ZERO + $urandom_range(7)));
    end else if (pick < 80) begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_UPPER_C);
      case ($urandom_range(5))
        0: text.push_back(CH_QUESTION);
        1: text.push_back(CH_TILDE);
        2: text.push_back(CH_SLASH);
        3: text.push_back(8'(CH_UPPER_A + $urandom_range(25)));
        4: text.push_back(8'(CH_LOWER_A + $urandom_range(25)));
        default: text.push_back(8'(CH_UPPER_Z + $urandom_range(1, 5)));
      endcase
    end else if (pick < 88) begin
      text.push_back(CH_BSLASH);
      text.push_back(8'($urandom_range(255)));
    end else if (pick < 94) begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_UPPER_C);
      text.push_back(8'($urandom_range(255)));
    end else if (pick < 97) begin
      text.push_back(CH_BSLASH);
    end else begin
      text.push_back(CH_BSLASH);
      text.push_back(CH_UPPER_C);
    end
  endtask

  task automatic send_random_string();
    logic [7:0] text[$];
    repeat ($urandom_range(1, 6)) add_token(text);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\\777\\0", 1'b1);
    send_text("\\12\\n", 1'b1);
    send_text("\\C[\\C", 1'b0);
    send_byte(8'hE1, 1'b0);
    send_text("\\C", 1'b1);
    send_text("\\x\\", 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      while (chars_sent < 26 + (phase + 1) * ITEMS_PER_PHASE) send_random_string();
      // The sender holds off here until every decoded byte has had its transfer.
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("escape_sequence_decoder_test OK");
    end else begin
      $display("escape_sequence_decoder_test NOT OK");
    end
    $finish;
  end

endmodule
